[rtl/imadec_pkg.sv]
// Shared types, constants and tables for the stereo IMA ADPCM decoder.
// No dependencies; imported by imadec_nib and ima_adpcm_stereo_decoder.
`default_nettype none

package imadec_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES     = 1'b1;

  localparam logic [15:0] SPB_RESET = 16'd505;
  localparam logic [6:0]  IDX_MAX   = 7'd88;
  localparam int unsigned STEP_N    = 89;

  localparam logic signed [17:0] SMP_MAX = 18'sd32767;
  localparam logic signed [17:0] SMP_MIN = -18'sd32768;

  localparam logic [14:0] STEP_TBL [STEP_N] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // per-channel decoder state
  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } chan_t;

  function automatic logic [14:0] step_size(input logic [6:0] i);
    logic [14:0] s;
    if (i > IDX_MAX) begin
      s = STEP_TBL[IDX_MAX];
    end else begin
      s = STEP_TBL[i];
    end
    return s;
  endfunction

  function automatic logic signed [7:0] idx_adj(input logic [2:0] mag);
    logic signed [7:0] a;
    if (mag[2]) begin
      a = 8'(signed'({4'd0, mag[1:0], 1'b0}) + 8'sd2);
    end else begin
      a = -8'sd1;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/imadec_nib.sv]
// One IMA ADPCM nibble step: step-table delta, sample and index saturation.
// Purely combinational; depends on imadec_pkg.
`default_nettype none

module imadec_nib (
  input  imadec_pkg::chan_t st,
  input  logic [3:0]        nib,
  output imadec_pkg::chan_t st_nxt
);
  import imadec_pkg::*;

  logic [14:0]        step;
  logic [15:0]        delta;
  logic signed [17:0] sum;
  logic signed [8:0]  si;

  always_comb begin
    step  = step_size(st.idx);
    delta = {4'd0, step[14:3]};
    if (nib[0]) delta = delta + {3'd0, step[14:2]};
    if (nib[1]) delta = delta + {2'd0, step[14:1]};
    if (nib[2]) delta = delta + {1'b0, step};

    if (nib[3]) begin
      sum = 18'(st.pred) - signed'({2'b00, delta});
    end else begin
      sum = 18'(st.pred) + signed'({2'b00, delta});
    end

    if (sum > SMP_MAX) begin
      st_nxt.pred = SMP_MAX[15:0];
    end else if (sum < SMP_MIN) begin
      st_nxt.pred = SMP_MIN[15:0];
    end else begin
      st_nxt.pred = sum[15:0];
    end

    si = signed'({2'b00, st.idx}) + 9'(idx_adj(nib[2:0]));
    if (si < 0) begin
      st_nxt.idx = '0;
    end else if (si > signed'({2'b00, IDX_MAX})) begin
      st_nxt.idx = IDX_MAX;
    end else begin
      st_nxt.idx = si[6:0];
    end
  end

endmodule

`default_nettype wire

[rtl/ima_adpcm_stereo_decoder.sv]
// Top level of the stereo IMA ADPCM block decoder: input byte register,
// framing control, two nibble decoders and the output pair register.
// Depends on imadec_pkg and imadec_nib.
//
// Usage: compressed bytes enter on in_data_byte with in_valid/in_stall; decoded
// stereo pairs leave on out_* with out_valid/out_stall. A beat moves when valid
// is high and stall is low. cfg_valid/cfg_ready writes samples_per_block
// (index 0) or total_samples (index 1); cfg_ready is always high.
// Output: a pair is registered at the output from the byte held in the input
// register once the output register can take it; the high-nibble pair of a
// right byte follows from the same held byte.
// Flow: a right data byte holds the input register for both of its pairs, low
// nibbles then high nibbles (only the low-nibble pair if the block or stream
// ends after it). Of the header bytes only the last yields a pair; left data
// bytes yield none, so a full data group of eight bytes gives eight pairs.
// While the receiver stalls a pending pair, left bytes and other header bytes
// pass; a byte that yields a pair waits in the input register, in_stall high.
// Reset: decoder state cleared, a block header is expected, pair count zero,
// samples_per_block = 505, total_samples = 0.
`default_nettype none

module ima_adpcm_stereo_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   out_left_sample,
  output logic signed [15:0]                   out_right_sample,
  output logic                                 out_last_of_run,
  output logic                                 out_stream_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [imadec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imadec_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import imadec_pkg::*;

  // configuration
  logic [15:0] spb_r;
  logic [31:0] total_r;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_take;

  // decoder state
  chan_t       ch_r [2];
  chan_t       ch_nxt [2];
  chan_t       dec_out [2];
  logic [15:0] blk_cnt_r, blk_cnt_nxt;
  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [2:0]  grp_pos_r, grp_pos_nxt;
  logic [31:0] pair_idx_r, pair_idx_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  lsel_r, lsel_nxt;
  logic [7:0]  lstore_r [4];
  logic [7:0]  hdr_lo_r;
  logic        lstore_we, hdr_lo_we;

  // step control
  logic        want_emit, done, last, end_hit, can_emit, fire;
  logic [15:0] blk_base, cnt_after;
  logic [7:0]  lbyte;
  logic [3:0]  nib_l, nib_r;
  logic        hch;

  // output register
  logic               out_vld_r;
  logic signed [15:0] out_l_r, out_r_r;
  logic               out_last_r, out_end_r;

  assign cfg_ready = 1'b1;

  assign lbyte = phase_r ? lstore_r[lsel_r] : lstore_r[grp_pos_r[1:0]];
  assign nib_l = phase_r ? lbyte[7:4] : lbyte[3:0];
  assign nib_r = phase_r ? in_byte_r[7:4] : in_byte_r[3:0];
  assign hch   = hdr_pos_r[2];

  imadec_nib u_nib_l (.st(ch_r[0]), .nib(nib_l), .st_nxt(dec_out[0]));
  imadec_nib u_nib_r (.st(ch_r[1]), .nib(nib_r), .st_nxt(dec_out[1]));

  always_comb begin
    ch_nxt[0]    = ch_r[0];
    ch_nxt[1]    = ch_r[1];
    blk_cnt_nxt  = blk_cnt_r;
    hdr_pos_nxt  = hdr_pos_r;
    grp_pos_nxt  = grp_pos_r;
    pair_idx_nxt = pair_idx_r;
    phase_nxt    = phase_r;
    lsel_nxt     = lsel_r;
    lstore_we    = 1'b0;
    hdr_lo_we    = 1'b0;
    want_emit    = 1'b0;
    done         = 1'b0;
    last         = 1'b0;
    blk_base     = blk_cnt_r;

    cnt_after = '0;
    end_hit   = ({1'b0, pair_idx_r} + 33'd1) >= {1'b0, total_r};

    if (in_vld_r) begin
      if (phase_r) begin
        // high nibbles of a right byte
        ch_nxt[0] = dec_out[0];
        ch_nxt[1] = dec_out[1];
        want_emit = 1'b1;
        last      = 1'b1;
        done      = 1'b1;
        phase_nxt = 1'b0;
      end else if (blk_cnt_r == '0) begin
        unique case (hdr_pos_r[1:0])
          2'd0: hdr_lo_we = 1'b1;
          2'd1: ch_nxt[hch].pred = signed'({in_byte_r, hdr_lo_r});
          2'd2: begin
            if (in_byte_r[7]) begin
              ch_nxt[hch].idx = '0;
            end else if (in_byte_r[6:0] > IDX_MAX) begin
              ch_nxt[hch].idx = IDX_MAX;
            end else begin
              ch_nxt[hch].idx = in_byte_r[6:0];
            end
          end
          default: ;
        endcase
        done = 1'b1;
        if (hdr_pos_r == 3'd7) begin
          hdr_pos_nxt = '0;
          grp_pos_nxt = '0;
          blk_base    = spb_r;
          want_emit   = 1'b1;
          last        = 1'b1;
        end else begin
          hdr_pos_nxt = hdr_pos_r + 3'd1;
        end
      end else begin
        grp_pos_nxt = grp_pos_r + 3'd1;
        if (!grp_pos_r[2]) begin
          lstore_we = 1'b1;
          done      = 1'b1;
        end else begin
          ch_nxt[0] = dec_out[0];
          ch_nxt[1] = dec_out[1];
          want_emit = 1'b1;
          lsel_nxt  = grp_pos_r[1:0];
        end
      end
    end

    if (want_emit) begin
      cnt_after    = (blk_base != '0) ? blk_base - 16'd1 : '0;
      blk_cnt_nxt  = cnt_after;
      pair_idx_nxt = pair_idx_r + 32'd1;
      // low-nibble pair: stop early on stream end or exhausted block
      if (!phase_r && blk_cnt_r != '0) begin
        if (end_hit || cnt_after == '0) begin
          last = 1'b1;
          done = 1'b1;
        end else begin
          phase_nxt = 1'b1;
        end
      end
      if (end_hit) begin
        pair_idx_nxt = '0;
        blk_cnt_nxt  = '0;
        hdr_pos_nxt  = '0;
        grp_pos_nxt  = '0;
      end
    end
  end

  assign can_emit = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && (!want_emit || can_emit);
  assign in_stall = in_vld_r && !(fire && done);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r      <= SPB_RESET;
      total_r    <= '0;
      in_vld_r   <= 1'b0;
      ch_r[0]    <= '0;
      ch_r[1]    <= '0;
      blk_cnt_r  <= '0;
      hdr_pos_r  <= '0;
      grp_pos_r  <= '0;
      pair_idx_r <= '0;
      phase_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SAMPLES_PER_BLOCK: spb_r   <= cfg_data[15:0];
          REG_TOTAL_SAMPLES:     total_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire && done) begin
        in_vld_r <= 1'b0;
      end

      if (fire) begin
        ch_r[0]    <= ch_nxt[0];
        ch_r[1]    <= ch_nxt[1];
        blk_cnt_r  <= blk_cnt_nxt;
        hdr_pos_r  <= hdr_pos_nxt;
        grp_pos_r  <= grp_pos_nxt;
        pair_idx_r <= pair_idx_nxt;
        phase_r    <= phase_nxt;
      end

      if (fire && want_emit) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
    if (fire) begin
      lsel_r <= lsel_nxt;
      if (lstore_we) begin
        lstore_r[grp_pos_r[1:0]] <= in_byte_r;
      end
      if (hdr_lo_we) begin
        hdr_lo_r <= in_byte_r;
      end
    end
    if (fire && want_emit) begin
      out_l_r    <= ch_nxt[0].pred;
      out_r_r    <= ch_nxt[1].pred;
      out_last_r <= last;
      out_end_r  <= end_hit;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_left_sample  = out_l_r;
  assign out_right_sample = out_r_r;
  assign out_last_of_run  = out_last_r;
  assign out_stream_end   = out_end_r;

  // second half of a right byte only exists with the byte still held
  a_phase_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> in_vld_r)
    else $error("second nibble pair pending without an input byte");

  a_phase_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r) |-> blk_cnt_r != '0)
    else $error("second nibble pair started outside a data block");

  a_hdr_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    blk_cnt_r != '0 |-> hdr_pos_r == '0)
    else $error("header position left nonzero inside a data block");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r[0].idx <= IDX_MAX && ch_r[1].idx <= IDX_MAX)
    else $error("step index above table range");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && want_emit && end_hit |=> pair_idx_r == '0 && blk_cnt_r == '0)
    else $error("stream end did not restart pair count and framing");

endmodule

`default_nettype wire
